// ===== hdl/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared constants and types for the centered binomial sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

   localparam int POLY_LENGTH = 768;
   localparam int COUNT_W     = $clog2(POLY_LENGTH);

   localparam int MODE_W = 3;
   localparam logic [MODE_W-1:0] ETA_2 = 3'd2;
   localparam logic [MODE_W-1:0] ETA_3 = 3'd3;
   localparam logic [MODE_W-1:0] ETA_4 = 3'd4;

   localparam int COEF_W  = 4;
   localparam int LANES   = 4;
   localparam int LANE_IW = $clog2(LANES);

   // one decoded byte (or eta 3 group): up to four coefficients
   typedef struct packed {
      logic [LANES-1:0][COEF_W-1:0] coefs;
      logic [LANE_IW-1:0]           last_idx;
   } job_type;

   // queue status seen by the front and back parts
   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== hdl/cbs_front.sv =====
// ----------------------------------------------------------------------------
// cbs_front
// Accepts random bytes, gathers eta 3 groups and decodes coefficient jobs.
// ----------------------------------------------------------------------------
module cbs_front import cbs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [MODE_W-1:0]   eta_mode,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_random_byte,
   input  queue_status_type    q_status,
   output logic                push,
   output job_type             push_job
);

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] group_pos_ff, group_pos_in;
   logic       accept;
   logic       is_eta3;
   logic       is_eta4;
   logic       gathering;

   // a minus b, both small counts, as 4-bit two's complement
   function automatic logic [COEF_W-1:0] diff(input logic [2:0] a, input logic [2:0] b);
      diff = {1'b0, a} - {1'b0, b};
   endfunction

   function automatic logic [2:0] ones2(input logic [1:0] v);
      ones2 = {2'b00, v[0]} + {2'b00, v[1]};
   endfunction

   function automatic logic [2:0] ones3(input logic a, input logic b, input logic c);
      ones3 = {2'b00, a} + {2'b00, b} + {2'b00, c};
   endfunction

   function automatic logic [2:0] ones4(input logic [3:0] v);
      ones4 = ones2(v[1:0]) + ones2(v[3:2]);
   endfunction

   assign is_eta3   = (eta_mode == ETA_3);
   assign is_eta4   = (eta_mode >= ETA_4);
   assign gathering = is_eta3 && (group_pos_ff < 2'd2);
   assign req_ready = q_status.not_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && !gathering;

   always_comb begin
      push_job = '0;
      if (is_eta3) begin
         for (int k = 0; k < LANES; k++) begin
            push_job.coefs[k] = diff(
               ones3(held0_ff[2*k], held1_ff[2*k], req_random_byte[2*k]),
               ones3(held0_ff[2*k+1], held1_ff[2*k+1], req_random_byte[2*k+1]));
         end
         push_job.last_idx = LANE_IW'(3);
      end else if (is_eta4) begin
         push_job.coefs[0] = diff(ones4(req_random_byte[3:0]), ones4(req_random_byte[7:4]));
         push_job.last_idx = LANE_IW'(0);
      end else begin
         push_job.coefs[0] = diff(ones2(req_random_byte[1:0]), ones2(req_random_byte[3:2]));
         push_job.coefs[1] = diff(ones2(req_random_byte[5:4]), ones2(req_random_byte[7:6]));
         push_job.last_idx = LANE_IW'(1);
      end
   end

   always_comb begin
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      group_pos_in = group_pos_ff;
      if (accept) begin
         if (is_eta3 && group_pos_ff == 2'd0) begin
            held0_in     = req_random_byte;
            group_pos_in = 2'd1;
         end else if (is_eta3 && group_pos_ff == 2'd1) begin
            held1_in     = req_random_byte;
            group_pos_in = 2'd2;
         end else begin
            group_pos_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      if (reset) begin
         group_pos_ff <= 2'd0;
      end else begin
         group_pos_ff <= group_pos_in;
      end
   end

endmodule

// ===== hdl/cbs_queue.sv =====
// ----------------------------------------------------------------------------
// cbs_queue
// Two-entry job queue between the decode front and the emit back.
// ----------------------------------------------------------------------------
module cbs_queue import cbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.not_full  = (count_ff != 2'd2);
   assign status.not_empty = (count_ff != 2'd0);
   assign head             = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/cbs_back.sv =====
// ----------------------------------------------------------------------------
// cbs_back
// Emits coefficients one per cycle unless stalled, tracks polynomial position.
// ----------------------------------------------------------------------------
module cbs_back import cbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  job_type            head,
   input  queue_status_type   q_status,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [3:0]  rsp_coefficient,
   output logic               rsp_last_of_run,
   output logic               rsp_polynomial_end
);

   logic [LANE_IW-1:0] lane_ff, lane_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         coef_ff;
   logic               last_ff;
   logic               pend_ff;
   logic               slot_free;
   logic               emit;
   logic               pend;
   logic               last;
   logic [COUNT_W:0]   count_next;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign emit       = q_status.not_empty && slot_free;
   assign count_next = {1'b0, count_ff} + (COUNT_W+1)'(1);
   assign pend       = (count_next >= (COUNT_W+1)'(POLY_LENGTH));
   // polynomial end drops the rest of the job
   assign last       = pend || (lane_ff == head.last_idx);
   assign pop        = emit && last;

   always_comb begin
      lane_in      = lane_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         lane_in      = last ? '0 : lane_ff + LANE_IW'(1);
         count_in     = pend ? '0 : count_next[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         coef_ff <= head.coefs[lane_ff];
         last_ff <= last;
         pend_ff <= pend;
      end
      if (reset) begin
         lane_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lane_ff      <= lane_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coefficient    = coef_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_polynomial_end = pend_ff;

endmodule

// ===== hdl/centered_binomial_sampler_core.sv =====
// A job is registered in the queue, then each coefficient in the output register.
// Rate: one coefficient per cycle from the output register while rsp_ready is high
//   and a job waits; eta 2 gives two per byte, eta 4 one, eta 3 four per three bytes.
// A two-entry job queue lets input bytes be taken while results stall.
// Reset (synchronous, active high): eta_mode 2, queue empty, counters and group cleared.
// ----------------------------------------------------------------------------
// centered_binomial_sampler_core
// Random bytes in, centered binomial coefficients out (eta 2, 3 or 4).
// ----------------------------------------------------------------------------
module centered_binomial_sampler_core import cbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_eta_mode,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_random_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [3:0]  rsp_coefficient,
   output logic               rsp_last_of_run,
   output logic               rsp_polynomial_end
);

   logic [MODE_W-1:0] eta_mode_ff, eta_mode_in;
   queue_status_type  q_status;
   job_type           push_job;
   job_type           head;
   logic              push;
   logic              pop;

   assign csr_ready   = 1'b1;
   assign eta_mode_in = (csr_valid && csr_ready) ? csr_eta_mode : eta_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_mode_ff <= ETA_2;
      end else begin
         eta_mode_ff <= eta_mode_in;
      end
   end

   cbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .eta_mode        (eta_mode_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_random_byte (req_random_byte),
      .q_status        (q_status),
      .push            (push),
      .push_job        (push_job)
   );

   cbs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   cbs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coefficient    (rsp_coefficient),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_polynomial_end (rsp_polynomial_end)
   );

endmodule

// ===== hdl/cbs_checker.sv =====
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks for the centered binomial sampler, bound to the core.
// ----------------------------------------------------------------------------
module cbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [3:0] rsp_coefficient,
   input logic              rsp_last_of_run,
   input logic              rsp_polynomial_end
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coefficient)
         && $stable(rsp_last_of_run) && $stable(rsp_polynomial_end))
      else $error("rsp item changed while stalled");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_polynomial_end |-> rsp_last_of_run)
      else $error("polynomial end without last_of_run");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_coefficient >= -4'sd4) && (rsp_coefficient <= 4'sd4))
      else $error("coefficient out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind centered_binomial_sampler_core cbs_checker u_cbs_checker (.*);

// ===== tb/centered_binomial_sampler_core_test.sv =====
// ----------------------------------------------------------------------------
// centered_binomial_sampler_core_test
// Feeds random bytes under every eta code and checks each coefficient, its
// run flag and its polynomial-end flag against an in-bench sampler model.
// ----------------------------------------------------------------------------
module centered_binomial_sampler_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cbs_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 150;
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 450;
   localparam logic [7:0] CORNER_BYTES [6] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h55, 8'hAA};

   typedef struct {
      logic signed [COEF_W-1:0] coefficient;
      logic                     last_of_run;
      logic                     polynomial_end;
   } coef_sample_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MODE_W-1:0] csr_eta_mode = ETA_2;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_random_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [3:0] rsp_coefficient;
   logic              rsp_last_of_run;
   logic              rsp_polynomial_end;

   // sampler model state
   logic [MODE_W-1:0] eta_now = ETA_2;
   logic [7:0]        held_pair [2] = '{8'h00, 8'h00};
   int                group_fill = 0;
   int                coef_index = 0;
   int                poly_ends = 0;

   logic [7:0]      pending_bytes [$];
   coef_sample_type expected_coefs [$];
   int              errors = 0;
   int              idle_cycles = 0;
   int              bytes_offered = 0;
   int              bytes_taken = 0;
   int              hold_requested = 0;
   int              hold_served = 0;

   centered_binomial_sampler_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_eta_mode       (csr_eta_mode),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_random_byte    (req_random_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coefficient    (rsp_coefficient),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_polynomial_end (rsp_polynomial_end)
   );

   always #4 clock = ~clock;

   // Works out the coefficients one accepted byte produces.
   task automatic expand_byte(input logic [7:0] b);
      int              lane [4];
      int              count;
      int              plus;
      int              minus;
      coef_sample_type s;
      if (eta_now == ETA_3) begin
         if (group_fill == 0) begin
            held_pair[0] = b;
            group_fill = 1;
            return;
         end
         if (group_fill == 1) begin
            held_pair[1] = b;
            group_fill = 2;
            return;
         end
         for (int k = 0; k < 4; k++) begin
            plus  = held_pair[0][2*k] + held_pair[1][2*k] + b[2*k];
            minus = held_pair[0][2*k+1] + held_pair[1][2*k+1] + b[2*k+1];
            lane[k] = plus - minus;
         end
         count = 4;
      end else if (eta_now >= ETA_4) begin
         lane[0] = $countones(b[3:0]) - $countones(b[7:4]);
         count = 1;
      end else begin
         lane[0] = int'(b[0]) + int'(b[1]) - int'(b[2]) - int'(b[3]);
         lane[1] = int'(b[4]) + int'(b[5]) - int'(b[6]) - int'(b[7]);
         count = 2;
      end
      group_fill = 0;
      for (int k = 0; k < count; k++) begin
         s.coefficient    = 4'(lane[k]);
         s.polynomial_end = (coef_index + 1 >= POLY_LENGTH);
         s.last_of_run    = s.polynomial_end || (k == count - 1);
         expected_coefs.push_back(s);
         if (s.polynomial_end) begin
            // rest of the byte or group is dropped
            coef_index = 0;
            poly_ends++;
            break;
         end
         coef_index++;
      end
   endtask

   always @(posedge clock) begin : monitor
      coef_sample_type want;
      if (!reset) begin
         idle_cycles++;
         if (csr_valid && csr_ready) begin
            eta_now = csr_eta_mode;
            idle_cycles = 0;
         end
         if (req_valid && req_ready) begin
            expand_byte(req_random_byte);
            bytes_taken++;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (expected_coefs.size() == 0) begin
               $error("coefficient %0d arrived with nothing expected", rsp_coefficient);
               errors++;
            end else begin
               want = expected_coefs.pop_front();
               if (rsp_coefficient !== want.coefficient) begin
                  $error("coefficient: expected %0d, actual %0d", want.coefficient,
                         rsp_coefficient);
                  errors++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                         rsp_last_of_run);
                  errors++;
               end
               if (rsp_polynomial_end !== want.polynomial_end) begin
                  $error("polynomial_end: expected %0b, actual %0b", want.polynomial_end,
                         rsp_polynomial_end);
                  errors++;
               end
            end
         end
      end
   end

   // sender: bursts of items separated by random gaps
   always @(negedge clock) begin : byte_driver
      logic       next_valid;
      logic [7:0] next_byte;
      int         burst_left;
      int         gap_left;
      next_valid = req_valid;
      next_byte  = req_random_byte;
      if (req_valid && bytes_taken == bytes_offered) begin
         next_valid = 1'b0;
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            case ($urandom_range(0, 3))
               0: begin gap_left = 0; burst_left = $urandom_range(20, 60); end
               1: begin gap_left = $urandom_range(1, 3); burst_left = $urandom_range(1, 8); end
               2: begin gap_left = $urandom_range(4, 20); burst_left = $urandom_range(1, 4); end
               default: begin
                  gap_left = $urandom_range(0, 1);
                  burst_left = $urandom_range(1, 3);
               end
            endcase
         end
      end
      if (!next_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_bytes.size() > 0) begin
            next_byte = pending_bytes.pop_front();
            next_valid = 1'b1;
            bytes_offered++;
         end
      end
      req_valid       <= next_valid;
      req_random_byte <= next_byte;
   end

   // receiver: stall style changes at random; long holds on request
   always @(negedge clock) begin : result_sink
      int style;
      int style_left;
      int hold_cycles;
      if (hold_served != hold_requested) begin
         rsp_ready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= LONG_HOLD) begin
            hold_cycles = 0;
            hold_served++;
         end
      end else begin
         if (style_left <= 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(16, 96);
         end
         style_left--;
         case (style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   initial begin : watchdog
      do @(negedge clock); while (idle_cycles < STALL_LIMIT);
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic write_eta(input logic [MODE_W-1:0] eta);
      @(negedge clock);
      csr_valid    <= 1'b1;
      csr_eta_mode <= eta;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // waits until every queued byte is taken and every coefficient is back
   task automatic drain();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || bytes_taken != bytes_offered ||
             expected_coefs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [MODE_W-1:0] eta;
      int                random_items;
      int                phase;
      int                len;
      random_items = 0;
      phase = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // eta 2 straight out of reset
      pending_bytes = '{8'h00, 8'hFF, 8'h03, 8'h0C, 8'h30, 8'hC0, 8'h55, 8'hAA};
      drain();
      write_eta(ETA_4);
      pending_bytes = '{8'h0F, 8'hF0, 8'h00, 8'hFF};
      drain();
      write_eta(ETA_3);
      pending_bytes = '{8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'h0F, 8'hF0, 8'h3C};
      drain();
      // unused codes fall back to eta 2 and eta 4
      write_eta(3'd0);
      pending_bytes = '{8'h5A};
      drain();
      write_eta(3'd7);
      pending_bytes = '{8'hE1};
      drain();
      // partial eta 3 group, then an eta 2 byte that restarts grouping
      write_eta(ETA_3);
      pending_bytes = '{8'h96};
      drain();
      write_eta(ETA_2);
      pending_bytes = '{8'h69};
      drain();

      while (random_items < RANDOM_ITEMS || poly_ends == 0) begin
         case ($urandom_range(0, 11))
            0:              eta = 3'd0;
            1:              eta = 3'd1;
            2, 3, 4, 5, 6:  eta = ETA_2;
            7, 8:           eta = ETA_3;
            9, 10:          eta = ETA_4;
            default:        eta = 3'($urandom_range(5, 7));
         endcase
         write_eta(eta);
         if (phase == 0 || phase == 5) hold_requested++;
         len = $urandom_range(20, 70);
         repeat (len) begin
            pending_bytes.push_back(($urandom_range(0, 7) == 0) ?
                                    CORNER_BYTES[$urandom_range(0, 5)] :
                                    8'($urandom_range(0, 255)));
         end
         random_items += len;
         drain();
         phase++;
      end

      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/cbs_pkg.sv
hdl/cbs_front.sv
hdl/cbs_queue.sv
hdl/cbs_back.sv
hdl/centered_binomial_sampler_core.sv
hdl/cbs_checker.sv
tb/centered_binomial_sampler_core_test.sv
